// ----- src/svc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svc_pkg
// shared types and constants of the space vector pwm compare calculator
// ----------------------------------------------------------------------------
package svc_pkg;

    // fixed field and datapath widths
    localparam int TS_BITS   = 16;
    localparam int NUM_W     = 34;
    localparam int MAG_W     = 32;
    localparam int Q1_W      = 33;
    localparam int SUM_W     = 34;
    localparam int PROD2_W   = 49;
    localparam int LANES1    = 3;
    localparam int LANES2    = 2;

    localparam logic [15:0] PERIOD_RESET = 16'd8400;

    // q15 coefficients
    localparam logic signed [NUM_W-1:0] SQRT3_Q15      = 34'sd56756;
    localparam logic signed [NUM_W-1:0] HALF_SQRT3_Q15 = 34'sd28378;
    localparam logic signed [NUM_W-1:0] THREE_HALF_Q15 = 34'sd49152;
    localparam logic signed [NUM_W-1:0] ONE_Q15        = 34'sd32768;

    // lanes of the first divider
    localparam int LANE_X = 0;
    localparam int LANE_Y = 1;
    localparam int LANE_Z = 2;

    // sector codes
    typedef logic [2:0] t_sector;
    localparam t_sector SECTOR_ZERO  = 3'd0;
    localparam t_sector SECTOR_1     = 3'd1;
    localparam t_sector SECTOR_2     = 3'd2;
    localparam t_sector SECTOR_3     = 3'd3;
    localparam t_sector SECTOR_4     = 3'd4;
    localparam t_sector SECTOR_5     = 3'd5;
    localparam t_sector SECTOR_6     = 3'd6;
    localparam t_sector SECTOR_SEVEN = 3'd7;

    typedef struct packed {
        logic signed [15:0] volt_alpha;
        logic signed [15:0] volt_beta;
        logic [15:0]        bus_volt;
    } t_svc_in;

    typedef struct packed {
        logic [14:0] cmp_a;
        logic [14:0] cmp_b;
        logic [14:0] cmp_c;
        t_sector     sector_code;
    } t_svc_out;

    // travels beside the x/y/z division
    typedef struct packed {
        t_sector     sector;
        logic [2:0]  neg;
    } t_svc_div1_side;

    // travels beside the overmodulation division
    typedef struct packed {
        t_sector     sector;
        logic        over;
        logic [15:0] t1;
        logic [15:0] t2;
    } t_svc_div2_side;

endpackage
`default_nettype wire

// ----- src/svc_udiv_pipe.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svc_udiv_pipe
// pipelined restoring divider, one quotient bit per stage, shared divisor
// ----------------------------------------------------------------------------
module svc_udiv_pipe #(
    parameter int QW    = 16,
    parameter int DW    = 16,
    parameter int LANES = 1,
    parameter int SW    = 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [LANES-1:0][DW-1:0]     i_rem,
    input  logic [LANES-1:0][QW-1:0]     i_num,
    input  logic [DW-1:0]                i_den,
    input  logic [SW-1:0]                i_side,
    output logic                         o_valid,
    output logic [LANES-1:0][QW-1:0]     o_quo,
    output logic [SW-1:0]                o_side
);

    logic                        r_v    [QW];
    logic [LANES-1:0][QW-1:0]    r_num  [QW];
    logic [SW-1:0]               r_side [QW];
    logic [LANES-1:0][DW-1:0]    r_rem  [QW-1];
    logic [DW-1:0]               r_den  [QW-1];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic                        w_v;
        logic [LANES-1:0][DW-1:0]    w_rem;
        logic [LANES-1:0][QW-1:0]    w_num;
        logic [DW-1:0]               w_den;
        logic [SW-1:0]               w_side;
        logic [LANES-1:0][DW-1:0]    n_rem;
        logic [LANES-1:0][QW-1:0]    n_num;

        if (k == 0) begin : g_first
            assign w_v    = i_valid;
            assign w_rem  = i_rem;
            assign w_num  = i_num;
            assign w_den  = i_den;
            assign w_side = i_side;
        end else begin : g_next
            assign w_v    = r_v[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_num  = r_num[k-1];
            assign w_den  = r_den[k-1];
            assign w_side = r_side[k-1];
        end

        // trial subtract per lane
        always_comb begin
            logic [DW:0] trial;
            logic [DW:0] diff;
            for (int l = 0; l < LANES; l++) begin
                trial = {w_rem[l], w_num[l][QW-1]};
                diff  = trial - {1'b0, w_den};
                if (trial >= {1'b0, w_den}) begin
                    n_rem[l] = diff[DW-1:0];
                    n_num[l] = {w_num[l][QW-2:0], 1'b1};
                end else begin
                    n_rem[l] = trial[DW-1:0];
                    n_num[l] = {w_num[l][QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[k]  <= n_num;
                r_side[k] <= w_side;
            end
        end

        if (k < QW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= n_rem;
                    r_den[k] <= w_den;
                end
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_quo   = r_num[QW-1];
    assign o_side  = r_side[QW-1];

endmodule
`default_nettype wire

// ----- src/svc_vec_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svc_vec_front
// sector decode and scaled x/y/z numerators, three stages
// ----------------------------------------------------------------------------
module svc_vec_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  svc_pkg::t_svc_in                   i_in,
    input  logic [15:0]                        i_ts,
    output logic                               o_valid,
    output logic [2:0][svc_pkg::Q1_W-1:0]      o_num,
    output logic [15:0]                        o_den,
    output svc_pkg::t_svc_div1_side            o_side
);
    import svc_pkg::*;

    // stage 1: numerators and sector
    logic                           r1_v;
    logic signed [NUM_W-1:0]        r1_n [LANES1];
    t_sector                        r1_sect;
    logic [15:0]                    r1_u;

    logic signed [NUM_W-1:0]        w_a;
    logic signed [NUM_W-1:0]        w_b;
    logic signed [NUM_W-1:0]        n1_n [LANES1];
    logic signed [NUM_W-1:0]        w_sb;
    logic signed [NUM_W-1:0]        w_sc;
    t_sector                        n1_sect;

    always_comb begin
        w_a = NUM_W'(i_in.volt_alpha);
        w_b = NUM_W'(i_in.volt_beta);
        n1_n[LANE_X] = SQRT3_Q15 * w_b;
        n1_n[LANE_Y] = THREE_HALF_Q15 * w_a + HALF_SQRT3_Q15 * w_b;
        n1_n[LANE_Z] = HALF_SQRT3_Q15 * w_b - THREE_HALF_Q15 * w_a;
        w_sb = SQRT3_Q15 * w_a - ONE_Q15 * w_b;
        w_sc = -(SQRT3_Q15 * w_a) - ONE_Q15 * w_b;
        n1_sect = {w_sc > 0, w_sb > 0, w_b > 0};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_n    <= n1_n;
            r1_sect <= n1_sect;
            r1_u    <= (i_in.bus_volt == 16'd0) ? 16'd1 : i_in.bus_volt;
        end
    end

    // stage 2: magnitudes
    logic                           r2_v;
    logic [MAG_W-1:0]               r2_mag [LANES1];
    logic [2:0]                     r2_neg;
    t_sector                        r2_sect;
    logic [15:0]                    r2_u;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < LANES1; l++) begin
                r2_neg[l] <= r1_n[l][NUM_W-1];
                r2_mag[l] <= r1_n[l][NUM_W-1] ? MAG_W'(-r1_n[l]) : MAG_W'(r1_n[l]);
            end
            r2_sect <= r1_sect;
            r2_u    <= r1_u;
        end
    end

    // stage 3: times period, drop the q15 scale
    logic                           r3_v;
    logic [2:0][Q1_W-1:0]           r3_q;
    logic [2:0]                     r3_neg;
    t_sector                        r3_sect;
    logic [15:0]                    r3_u;
    logic [MAG_W+15:0]              w_prod [LANES1];

    always_comb begin
        for (int l = 0; l < LANES1; l++) begin
            w_prod[l] = (MAG_W+16)'(r2_mag[l]) * (MAG_W+16)'(i_ts);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < LANES1; l++) begin
                r3_q[l] <= w_prod[l][MAG_W+15:15];
            end
            r3_neg  <= r2_neg;
            r3_sect <= r2_sect;
            r3_u    <= r2_u;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    assign o_valid       = r3_v;
    assign o_num         = r3_q;
    assign o_den         = r3_u;
    assign o_side.sector = r3_sect;
    assign o_side.neg    = r3_neg;

endmodule
`default_nettype wire

// ----- src/svc_time_scale.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svc_time_scale
// active vector times per sector, overmodulation test and scaling products
// ----------------------------------------------------------------------------
module svc_time_scale (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  logic [2:0][svc_pkg::Q1_W-1:0]        i_q,
    input  svc_pkg::t_svc_div1_side              i_side,
    input  logic [15:0]                          i_ts,
    output logic                                 o_valid,
    output logic [1:0][svc_pkg::SUM_W-1:0]       o_rem,
    output logic [1:0][15:0]                     o_num,
    output logic [svc_pkg::SUM_W-1:0]            o_den,
    output svc_pkg::t_svc_div2_side              o_side
);
    import svc_pkg::*;

    // positive part of a signed quotient, flip negates first
    function automatic logic [Q1_W-1:0] pos_part(
        input logic [Q1_W-1:0] q,
        input logic            neg,
        input logic            flip
    );
        return (neg ^ flip) ? '0 : q;
    endfunction

    // stage 1: pick t1, t2 and clamp at zero
    logic                r1_v;
    logic [Q1_W-1:0]     r1_t1;
    logic [Q1_W-1:0]     r1_t2;
    t_sector             r1_sect;
    logic [Q1_W-1:0]     n1_t1;
    logic [Q1_W-1:0]     n1_t2;

    always_comb begin
        unique case (i_side.sector)
            SECTOR_1: begin
                n1_t1 = pos_part(i_q[LANE_Z], i_side.neg[LANE_Z], 1'b0);
                n1_t2 = pos_part(i_q[LANE_Y], i_side.neg[LANE_Y], 1'b0);
            end
            SECTOR_2: begin
                n1_t1 = pos_part(i_q[LANE_Y], i_side.neg[LANE_Y], 1'b0);
                n1_t2 = pos_part(i_q[LANE_X], i_side.neg[LANE_X], 1'b1);
            end
            SECTOR_3: begin
                n1_t1 = pos_part(i_q[LANE_Z], i_side.neg[LANE_Z], 1'b1);
                n1_t2 = pos_part(i_q[LANE_X], i_side.neg[LANE_X], 1'b0);
            end
            SECTOR_4: begin
                n1_t1 = pos_part(i_q[LANE_X], i_side.neg[LANE_X], 1'b1);
                n1_t2 = pos_part(i_q[LANE_Z], i_side.neg[LANE_Z], 1'b0);
            end
            SECTOR_5: begin
                n1_t1 = pos_part(i_q[LANE_X], i_side.neg[LANE_X], 1'b0);
                n1_t2 = pos_part(i_q[LANE_Y], i_side.neg[LANE_Y], 1'b1);
            end
            SECTOR_6: begin
                n1_t1 = pos_part(i_q[LANE_Y], i_side.neg[LANE_Y], 1'b1);
                n1_t2 = pos_part(i_q[LANE_Z], i_side.neg[LANE_Z], 1'b1);
            end
            default: begin
                n1_t1 = '0;
                n1_t2 = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_t1   <= n1_t1;
            r1_t2   <= n1_t2;
            r1_sect <= i_side.sector;
        end
    end

    // stage 2: sum and overmodulation flag
    logic                r2_v;
    logic [Q1_W-1:0]     r2_t1;
    logic [Q1_W-1:0]     r2_t2;
    logic [SUM_W-1:0]    r2_sum;
    logic                r2_over;
    t_sector             r2_sect;
    logic [SUM_W-1:0]    w_sum;

    assign w_sum = SUM_W'(r1_t1) + SUM_W'(r1_t2);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_t1   <= r1_t1;
            r2_t2   <= r1_t2;
            r2_sum  <= w_sum;
            r2_over <= w_sum > SUM_W'(i_ts);
            r2_sect <= r1_sect;
        end
    end

    // stage 3: times period for the rescale
    logic                r3_v;
    logic [PROD2_W-1:0]  r3_p [LANES2];
    logic [SUM_W-1:0]    r3_sum;
    t_svc_div2_side      r3_side;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_p[0]        <= PROD2_W'(r2_t1) * PROD2_W'(i_ts);
            r3_p[1]        <= PROD2_W'(r2_t2) * PROD2_W'(i_ts);
            r3_sum         <= r2_sum;
            r3_side.sector <= r2_sect;
            r3_side.over   <= r2_over;
            r3_side.t1     <= r2_t1[15:0];
            r3_side.t2     <= r2_t2[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    // high part is already below the sum, only 16 quotient bits remain
    always_comb begin
        for (int l = 0; l < LANES2; l++) begin
            o_rem[l] = SUM_W'(r3_p[l][PROD2_W-1:16]);
            o_num[l] = r3_p[l][15:0];
        end
    end

    assign o_valid = r3_v;
    assign o_den   = r3_sum;
    assign o_side  = r3_side;

endmodule
`default_nettype wire

// ----- src/svc_cmp_map.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svc_cmp_map
// segment times and phase mapping into the output register
// ----------------------------------------------------------------------------
module svc_cmp_map (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [1:0][15:0]           i_q,
    input  svc_pkg::t_svc_div2_side    i_side,
    input  logic [15:0]                i_ts,
    output logic                       o_valid,
    output svc_pkg::t_svc_out          o_out
);
    import svc_pkg::*;

    logic        r_v;
    t_svc_out    r_out;
    logic [15:0] w_t1;
    logic [15:0] w_t2;
    logic [17:0] w_sum;
    logic [17:0] w_ta;
    logic [17:0] w_tb;
    logic [17:0] w_tc;
    t_svc_out    n_out;

    always_comb begin
        w_t1  = i_side.over ? i_q[0] : i_side.t1;
        w_t2  = i_side.over ? i_q[1] : i_side.t2;
        w_sum = 18'(w_t1) + 18'(w_t2);
        w_ta  = 18'(i_ts) - w_sum;
        w_tb  = 18'(i_ts) + 18'(w_t1) - 18'(w_t2);
        w_tc  = 18'(i_ts) + w_sum;
        n_out.sector_code = i_side.sector;
        unique case (i_side.sector)
            SECTOR_1: begin
                n_out.cmp_a = w_tb[16:2];
                n_out.cmp_b = w_ta[16:2];
                n_out.cmp_c = w_tc[16:2];
            end
            SECTOR_2: begin
                n_out.cmp_a = w_ta[16:2];
                n_out.cmp_b = w_tc[16:2];
                n_out.cmp_c = w_tb[16:2];
            end
            SECTOR_3: begin
                n_out.cmp_a = w_ta[16:2];
                n_out.cmp_b = w_tb[16:2];
                n_out.cmp_c = w_tc[16:2];
            end
            SECTOR_4: begin
                n_out.cmp_a = w_tc[16:2];
                n_out.cmp_b = w_tb[16:2];
                n_out.cmp_c = w_ta[16:2];
            end
            SECTOR_5: begin
                n_out.cmp_a = w_tc[16:2];
                n_out.cmp_b = w_ta[16:2];
                n_out.cmp_c = w_tb[16:2];
            end
            SECTOR_6: begin
                n_out.cmp_a = w_tb[16:2];
                n_out.cmp_b = w_tc[16:2];
                n_out.cmp_c = w_ta[16:2];
            end
            default: begin
                n_out.cmp_a = w_ta[16:2];
                n_out.cmp_b = w_ta[16:2];
                n_out.cmp_c = w_ta[16:2];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_v;
    assign o_out   = r_out;

endmodule
`default_nettype wire

// ----- src/svpwm_compare_calc_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svpwm_compare_calc_unit
// seven-segment space vector pwm: sector, active times, overmodulation,
// three phase compare values
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  in        input      i_valid / o_ready      i_in  (alpha, beta, bus volt)
//  out       output     o_valid / i_ready      o_out (cmp a/b/c, sector)
//  cfg       input      i_cfg_we               i_cfg_data (period counts)
//
//  one vector per cycle while the output is not held; path from in to out: input
//  register, 3 front stages, 33-stage x/y/z divider, 3 time stages, 16-stage
//  rescale divider, output register; the divider stage chains set the latency
//  synchronous active-low reset clears all valid bits and loads period 8400
//  a waiting result freezes the pipeline; the input register still fills
//  if empty, so no transfer is lost or repeated
// ----------------------------------------------------------------------------
module svpwm_compare_calc_unit #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  svc_pkg::t_svc_in    i_in,
    output logic                o_valid,
    input  logic                i_ready,
    output svc_pkg::t_svc_out   o_out,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_data
);
    import svc_pkg::*;

    // only the low bits of the period are kept, at most 16
    localparam int TS_W   = (COUNT_WIDTH < TS_BITS) ? COUNT_WIDTH : TS_BITS;
    localparam int D1S_W  = $bits(t_svc_div1_side);
    localparam int D2S_W  = $bits(t_svc_div2_side);

    logic [TS_W-1:0] r_period;
    logic [15:0]     w_ts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET[TS_W-1:0];
        end else if (i_cfg_we) begin
            r_period <= i_cfg_data[TS_W-1:0];
        end
    end

    assign w_ts = 16'(r_period);

    // pipeline advance: output empty or being taken
    logic w_en;
    logic w_out_valid;

    assign w_en = !w_out_valid || i_ready;

    // input register, also fills while the rest is held if it is empty
    logic     r_in_valid;
    t_svc_in  r_in;
    logic     w_in_load;

    assign o_ready   = w_en || !r_in_valid;
    assign w_in_load = o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_load) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_load && i_valid) begin
            r_in <= i_in;
        end
    end

    // sector and numerators
    logic                    w_fr_valid;
    logic [2:0][Q1_W-1:0]    w_fr_num;
    logic [15:0]             w_fr_den;
    t_svc_div1_side          w_fr_side;

    svc_vec_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_in_valid),
        .i_in    (r_in),
        .i_ts    (w_ts),
        .o_valid (w_fr_valid),
        .o_num   (w_fr_num),
        .o_den   (w_fr_den),
        .o_side  (w_fr_side)
    );

    // x, y, z magnitudes divided by bus voltage
    logic [D1S_W-1:0]        w_d1_side_in;
    logic [D1S_W-1:0]        w_d1_side_out;
    logic                    w_d1_valid;
    logic [2:0][Q1_W-1:0]    w_d1_quo;
    t_svc_div1_side          w_d1_side;

    assign w_d1_side_in = w_fr_side;
    assign w_d1_side    = w_d1_side_out;

    svc_udiv_pipe #(
        .QW    (Q1_W),
        .DW    (16),
        .LANES (LANES1),
        .SW    (D1S_W)
    ) u_div_xyz (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_fr_valid),
        .i_rem   ('0),
        .i_num   (w_fr_num),
        .i_den   (w_fr_den),
        .i_side  (w_d1_side_in),
        .o_valid (w_d1_valid),
        .o_quo   (w_d1_quo),
        .o_side  (w_d1_side_out)
    );

    // active vector times and rescale products
    logic                    w_tm_valid;
    logic [1:0][SUM_W-1:0]   w_tm_rem;
    logic [1:0][15:0]        w_tm_num;
    logic [SUM_W-1:0]        w_tm_den;
    t_svc_div2_side          w_tm_side;

    svc_time_scale u_time (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_d1_valid),
        .i_q     (w_d1_quo),
        .i_side  (w_d1_side),
        .i_ts    (w_ts),
        .o_valid (w_tm_valid),
        .o_rem   (w_tm_rem),
        .o_num   (w_tm_num),
        .o_den   (w_tm_den),
        .o_side  (w_tm_side)
    );

    // overmodulation rescale t * period / (t1 + t2)
    logic [D2S_W-1:0]        w_d2_side_in;
    logic [D2S_W-1:0]        w_d2_side_out;
    logic                    w_d2_valid;
    logic [1:0][15:0]        w_d2_quo;
    t_svc_div2_side          w_d2_side;

    assign w_d2_side_in = w_tm_side;
    assign w_d2_side    = w_d2_side_out;

    svc_udiv_pipe #(
        .QW    (16),
        .DW    (SUM_W),
        .LANES (LANES2),
        .SW    (D2S_W)
    ) u_div_over (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_tm_valid),
        .i_rem   (w_tm_rem),
        .i_num   (w_tm_num),
        .i_den   (w_tm_den),
        .i_side  (w_d2_side_in),
        .o_valid (w_d2_valid),
        .o_quo   (w_d2_quo),
        .o_side  (w_d2_side_out)
    );

    // compare values into the output register
    svc_cmp_map u_cmp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_d2_valid),
        .i_q     (w_d2_quo),
        .i_side  (w_d2_side),
        .i_ts    (w_ts),
        .o_valid (w_out_valid),
        .o_out   (o_out)
    );

    assign o_valid = w_out_valid;

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // zero vector gives equal compares
    a_zero_vec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_out.sector_code == SECTOR_ZERO || o_out.sector_code == SECTOR_SEVEN)
        |-> (o_out.cmp_a == o_out.cmp_b) && (o_out.cmp_b == o_out.cmp_c))
        else $error("zero vector compares differ");

    // no compare beyond half the period
    a_cmp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (16'(o_out.cmp_a) <= {1'b0, w_ts[15:1]})
                 && (16'(o_out.cmp_b) <= {1'b0, w_ts[15:1]})
                 && (16'(o_out.cmp_c) <= {1'b0, w_ts[15:1]}))
        else $error("compare above half period");

endmodule
`default_nettype wire
